[rtl/rv32x_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rv32x_pkg;

  localparam int REG_COUNT     = 32;
  localparam int REG_AW        = 5;
  localparam int XLEN          = 32;
  localparam int MEM_BYTES_DEF = 4096;
  localparam int MEM_ADDR_W    = 12;

  localparam logic [4:0] OP_ADD  = 5'd0;
  localparam logic [4:0] OP_SUB  = 5'd1;
  localparam logic [4:0] OP_AND  = 5'd2;
  localparam logic [4:0] OP_OR   = 5'd3;
  localparam logic [4:0] OP_XOR  = 5'd4;
  localparam logic [4:0] OP_SLT  = 5'd5;
  localparam logic [4:0] OP_SLL  = 5'd6;
  localparam logic [4:0] OP_SRA  = 5'd7;
  localparam logic [4:0] OP_ADDI = 5'd8;
  localparam logic [4:0] OP_ANDI = 5'd9;
  localparam logic [4:0] OP_ORI  = 5'd10;
  localparam logic [4:0] OP_XORI = 5'd11;
  localparam logic [4:0] OP_SLTI = 5'd12;
  localparam logic [4:0] OP_LW   = 5'd13;
  localparam logic [4:0] OP_LB   = 5'd14;
  localparam logic [4:0] OP_SW   = 5'd15;
  localparam logic [4:0] OP_SB   = 5'd16;
  localparam logic [4:0] OP_LUI  = 5'd17;

  typedef struct packed {
    logic [4:0]             op;
    logic [REG_AW-1:0]      dest_reg;
    logic [REG_AW-1:0]      src1_reg;
    logic [REG_AW-1:0]      src2_reg;
    logic signed [XLEN-1:0] immediate;
  } item_t;

  typedef struct packed {
    logic                   reg_written;
    logic [REG_AW-1:0]      written_reg;
    logic signed [XLEN-1:0] written_value;
    logic                   mem_written;
    logic [MEM_ADDR_W-1:0]  mem_address;
  } result_t;

endpackage

`default_nettype wire

[rtl/rv32x_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module rv32x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/rv32_subset_execute_unit_top.sv]
// Executes one decoded instruction of a small RV32I integer subset per transaction and
// returns one result transaction describing the register or memory write it made. The
// register file lives in two synchronous RAM copies (one per read port) and the data memory
// in four byte-lane RAM banks, so a misaligned or wrapping word access still takes a single
// memory access. Items flow through an operand stage and a memory/write-back stage into an
// output register: one transaction is accepted per clock while no stall holds the input.
// An item that reads the destination of a load directly ahead of it waits in the operand
// stage for the load data. After reset the data memory is cleared one row per cycle, all
// MEM_BYTES/4 rows, with the input stalled. MEM_BYTES must be a power of two of at least 4.
`timescale 1ns / 1ps
`default_nettype none

module rv32_subset_execute_unit_top #(
  parameter int MEM_BYTES = rv32x_pkg::MEM_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire rv32x_pkg::item_t  item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output rv32x_pkg::result_t     result
);

  import rv32x_pkg::*;

  localparam int ROWS = MEM_BYTES / 4;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [XLEN-1:0] ADDR_MASK = XLEN'(MEM_BYTES - 1);

  typedef struct packed {
    logic                  reg_written;
    logic [REG_AW-1:0]     rd;
    logic [XLEN-1:0]       value;
    logic                  mem_written;
    logic [MEM_ADDR_W-1:0] mem_addr;
    logic                  is_load;
    logic                  is_lw;
    logic [1:0]            off;
  } s2_t;

  logic              in_fire;
  logic              s1_valid;
  logic              s2_valid;
  logic              s1_adv;
  logic              s2_adv;
  logic              hazard;
  item_t             s1_item;
  logic [REG_AW-1:0] s1_b_addr;
  logic [REG_AW-1:0] b_addr_in;
  s2_t               s2;
  s2_t               s2_next;
  result_t           result_next;

  logic [REG_COUNT-1:0] rf_valid;
  logic                 rf_we;
  logic [REG_AW-1:0]    rf_waddr;
  logic [XLEN-1:0]      rf_wdata;
  logic [XLEN-1:0]      rf_qa;
  logic [XLEN-1:0]      rf_qb;
  logic                 rv_a;
  logic                 rv_b;
  logic                 byp_a_v;
  logic                 byp_b_v;
  logic [XLEN-1:0]      byp_a_d;
  logic [XLEN-1:0]      byp_b_d;
  logic [XLEN-1:0]      opa;
  logic [XLEN-1:0]      opb;

  logic            clearing;
  logic [RW-1:0]   clr_row;
  logic [XLEN-1:0] imm_u;
  logic [XLEN-1:0] alu_res;
  logic [XLEN-1:0] eff;
  logic [1:0]      off;
  logic            s1_load;
  logic            s1_store;
  logic            s1_do_reg;
  logic [1:0]      lane_k   [4];
  logic [XLEN-1:0] lane_addr[4];
  logic [RW-1:0]   lane_row [4];
  logic [7:0]      lane_wd  [4];
  logic            lane_we  [4];
  logic [7:0]      bank_q   [4];
  logic [7:0]      ld_byte  [4];
  logic [XLEN-1:0] s2_final;

  assign s2_adv     = s2_valid && (!result_valid || !result_stall);
  assign hazard     = s2_valid && s2.is_load && s2.reg_written &&
                      (s2.rd == s1_item.src1_reg || s2.rd == s1_b_addr);
  assign s1_adv     = s1_valid && !hazard && (!s2_valid || s2_adv);
  assign item_stall = rst || clearing || (s1_valid && !s1_adv);
  assign in_fire    = item_valid && !item_stall;
  assign b_addr_in  = (item.op == OP_SW || item.op == OP_SB) ? item.dest_reg : item.src2_reg;

  assign rf_we    = s2_adv && s2.reg_written;
  assign rf_waddr = s2.rd;
  assign rf_wdata = s2_final;

  rv32x_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (in_fire),
    .raddr (item.src1_reg),
    .rdata (rf_qa)
  );

  rv32x_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (in_fire),
    .raddr (b_addr_in),
    .rdata (rf_qb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
      byp_a_v  <= 1'b0;
      byp_b_v  <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_valid[rf_waddr] <= 1'b1;
      end
      if (in_fire) begin
        rv_a    <= rf_valid[item.src1_reg];
        rv_b    <= rf_valid[b_addr_in];
        byp_a_v <= rf_we && (rf_waddr == item.src1_reg);
        byp_b_v <= rf_we && (rf_waddr == b_addr_in);
        byp_a_d <= rf_wdata;
        byp_b_d <= rf_wdata;
      end else if (rf_we) begin
        if (rf_waddr == s1_item.src1_reg) begin
          byp_a_v <= 1'b1;
          byp_a_d <= rf_wdata;
        end
        if (rf_waddr == s1_b_addr) begin
          byp_b_v <= 1'b1;
          byp_b_d <= rf_wdata;
        end
      end
    end
  end

  always_comb begin
    if (s2_valid && s2.reg_written && !s2.is_load && s2.rd == s1_item.src1_reg) begin
      opa = s2.value;
    end else if (byp_a_v) begin
      opa = byp_a_d;
    end else begin
      opa = rv_a ? rf_qa : '0;
    end
    if (s2_valid && s2.reg_written && !s2.is_load && s2.rd == s1_b_addr) begin
      opb = s2.value;
    end else if (byp_b_v) begin
      opb = byp_b_d;
    end else begin
      opb = rv_b ? rf_qb : '0;
    end
  end

  assign imm_u = s1_item.immediate;
  assign eff   = opa + imm_u;
  assign off   = eff[1:0];

  always_comb begin
    case (s1_item.op)
      OP_ADD:  alu_res = opa + opb;
      OP_SUB:  alu_res = opa - opb;
      OP_AND:  alu_res = opa & opb;
      OP_OR:   alu_res = opa | opb;
      OP_XOR:  alu_res = opa ^ opb;
      OP_SLT:  alu_res = {{(XLEN-1){1'b0}}, ($signed(opa) < $signed(opb))};
      OP_SLL:  alu_res = opa << opb[4:0];
      OP_SRA:  alu_res = XLEN'($signed(opa) >>> opb[4:0]);
      OP_ADDI: alu_res = opa + imm_u;
      OP_ANDI: alu_res = opa & imm_u;
      OP_ORI:  alu_res = opa | imm_u;
      OP_XORI: alu_res = opa ^ imm_u;
      OP_SLTI: alu_res = {{(XLEN-1){1'b0}}, ($signed(opa) < $signed(imm_u))};
      OP_LUI:  alu_res = imm_u << 12;
      default: alu_res = '0;
    endcase
  end

  always_comb begin
    s1_load   = s1_item.op inside {OP_LW, OP_LB};
    s1_store  = s1_item.op inside {OP_SW, OP_SB};
    s1_do_reg = s1_item.op inside {[OP_ADD:OP_SLTI], OP_LW, OP_LB, OP_LUI};
    for (int j = 0; j < 4; j++) begin
      lane_k[j]    = 2'(2'(j) - off);
      lane_addr[j] = (eff + {{(XLEN-2){1'b0}}, lane_k[j]}) & ADDR_MASK;
      lane_row[j]  = lane_addr[j][RW+1:2];
      lane_wd[j]   = 8'(opb >> {lane_k[j], 3'b000});
      lane_we[j]   = s1_adv && s1_store && (s1_item.op == OP_SW || lane_k[j] == 2'd0);
    end
    s2_next.reg_written = s1_do_reg && (s1_item.dest_reg != '0);
    s2_next.rd          = s2_next.reg_written ? s1_item.dest_reg : '0;
    s2_next.value       = alu_res;
    s2_next.mem_written = s1_store;
    s2_next.mem_addr    = (s1_load || s1_store) ? MEM_ADDR_W'(eff & ADDR_MASK) : '0;
    s2_next.is_load     = s1_load;
    s2_next.is_lw       = (s1_item.op == OP_LW);
    s2_next.off         = off;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      if (clr_row == RW'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
      clr_row <= RW'(clr_row + 1'b1);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    rv32x_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
      .clk   (clk),
      .we    (clearing || lane_we[g]),
      .waddr (clearing ? clr_row : lane_row[g]),
      .wdata (clearing ? 8'd0 : lane_wd[g]),
      .re    (s1_adv && s1_load),
      .raddr (lane_row[g]),
      .rdata (bank_q[g])
    );
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ld_byte[k] = bank_q[2'(s2.off + 2'(k))];
    end
    if (!s2.is_load) begin
      s2_final = s2.value;
    end else if (s2.is_lw) begin
      s2_final = {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};
    end else begin
      s2_final = {{(XLEN-8){ld_byte[0][7]}}, ld_byte[0]};
    end
    result_next.reg_written   = s2.reg_written;
    result_next.written_reg   = s2.rd;
    result_next.written_value = s2.reg_written ? s2_final : '0;
    result_next.mem_written   = s2.mem_written;
    result_next.mem_address   = s2.mem_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= in_fire || (s1_valid && !s1_adv);
      s2_valid     <= s1_adv || (s2_valid && !s2_adv);
      result_valid <= s2_adv || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item   <= item;
      s1_b_addr <= b_addr_in;
    end
    if (s1_adv) begin
      s2 <= s2_next;
    end
    if (s2_adv) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

[rtl/rv32x_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rv32x_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                item_stall,
  input wire logic                result_valid,
  input wire logic                result_stall,
  input wire rv32x_pkg::result_t  result
);

  import rv32x_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("Stalled result transaction changed or was dropped.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("Result transaction offered right after reset.");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> item_stall)
    else $error("Input not stalled while the data memory is being cleared.");

  a_store_no_reg: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.mem_written |-> !result.reg_written && result.written_value == '0)
    else $error("Store transaction reports a register write.");

  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.reg_written |-> result.written_reg != '0)
    else $error("Register write reported for x0.");

endmodule

bind rv32_subset_execute_unit_top rv32x_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

[test/rv32_subset_execute_unit_top_tb.sv]
`timescale 1ns / 1ps

module rv32_subset_execute_unit_top_tb;
  import rv32x_pkg::*;

  localparam int MEM_BYTES      = MEM_BYTES_DEF;
  localparam int RANDOM_PER_PHASE = 182;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  logic [31:0] arch_regs [REG_COUNT];
  logic [7:0]  arch_mem [MEM_BYTES];

  item_t   pending_items[$];
  result_t expected_results[$];

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  logic [4:0]  last_dest = '0;

  int send_idle_by_phase[4] = '{0, 45, 0, 23};
  int stall_by_phase[4]     = '{0, 0, 45, 23};

  rv32_subset_execute_unit_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] alu_result(input logic [4:0] sel, input logic [31:0] a,
                                             input logic [31:0] b);
    logic [31:0] value;
    case (sel)
      OP_ADD:  value = a + b;
      OP_SUB:  value = a - b;
      OP_AND:  value = a & b;
      OP_OR:   value = a | b;
      OP_XOR:  value = a ^ b;
      OP_SLT:  value = {31'b0, $signed(a) < $signed(b)};
      OP_SLL:  value = a << b[4:0];
      OP_SRA:  value = $signed(a) >>> b[4:0];
      default: value = '0;
    endcase
    return value;
  endfunction

  function automatic result_t execute_insn(input item_t it);
    logic [31:0] a;
    logic [31:0] imm;
    logic [31:0] value;
    logic [31:0] addr;
    logic [31:0] data;
    logic        do_reg;
    logic        do_mem;
    result_t     r;
    a = arch_regs[it.src1_reg];
    imm = it.immediate;
    value = '0;
    addr = '0;
    do_reg = 1'b0;
    do_mem = 1'b0;
    case (it.op)
      OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_SLT, OP_SLL, OP_SRA: begin
        value = alu_result(it.op, a, arch_regs[it.src2_reg]);
        do_reg = 1'b1;
      end
      OP_ADDI: begin value = alu_result(OP_ADD, a, imm); do_reg = 1'b1; end
      OP_ANDI: begin value = alu_result(OP_AND, a, imm); do_reg = 1'b1; end
      OP_ORI:  begin value = alu_result(OP_OR, a, imm);  do_reg = 1'b1; end
      OP_XORI: begin value = alu_result(OP_XOR, a, imm); do_reg = 1'b1; end
      OP_SLTI: begin value = alu_result(OP_SLT, a, imm); do_reg = 1'b1; end
      OP_LW: begin
        addr = (a + imm) % MEM_BYTES;
        for (int i = 0; i < 4; i++) begin
          value[8*i +: 8] = arch_mem[(addr + i) % MEM_BYTES];
        end
        do_reg = 1'b1;
      end
      OP_LB: begin
        addr = (a + imm) % MEM_BYTES;
        value = {{24{arch_mem[addr][7]}}, arch_mem[addr]};
        do_reg = 1'b1;
      end
      OP_SW: begin
        addr = (a + imm) % MEM_BYTES;
        data = arch_regs[it.dest_reg];
        for (int i = 0; i < 4; i++) begin
          arch_mem[(addr + i) % MEM_BYTES] = data[8*i +: 8];
        end
        do_mem = 1'b1;
      end
      OP_SB: begin
        addr = (a + imm) % MEM_BYTES;
        arch_mem[addr] = arch_regs[it.dest_reg][7:0];
        do_mem = 1'b1;
      end
      OP_LUI: begin value = imm << 12; do_reg = 1'b1; end
      default: ;
    endcase
    if (it.dest_reg == 5'd0) begin
      do_reg = 1'b0;
    end
    if (do_reg) begin
      arch_regs[it.dest_reg] = value;
    end
    r.reg_written   = do_reg;
    r.written_reg   = do_reg ? it.dest_reg : 5'd0;
    r.written_value = do_reg ? value : 32'd0;
    r.mem_written   = do_mem;
    r.mem_address   = addr[MEM_ADDR_W-1:0];
    return r;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(99) < 8) begin
      it.op = 5'($urandom_range(31, 18));
    end else begin
      it.op = 5'($urandom_range(17, 0));
    end
    it.dest_reg = 5'($urandom);
    it.src1_reg = 5'($urandom);
    it.src2_reg = 5'($urandom);
    if ($urandom_range(3) == 0) begin
      it.src1_reg = last_dest;
    end
    case ($urandom_range(3))
      0: it.immediate = r;
      1: it.immediate = {{20{r[11]}}, r[11:0]};
      2: begin
        case ($urandom_range(4))
          0: it.immediate = 32'h0000_0000;
          1: it.immediate = 32'h0000_0001;
          2: it.immediate = 32'hFFFF_FFFF;
          3: it.immediate = 32'h7FFF_FFFF;
          default: it.immediate = 32'h8000_0000;
        endcase
      end
      default: it.immediate = 32'($urandom_range(31));
    endcase
    if (it.op >= OP_LW && it.op <= OP_SB && $urandom_range(9) < 7) begin
      it.src1_reg = 5'd0;
      if ($urandom_range(3) == 0) begin
        it.immediate = 32'($urandom_range(MEM_BYTES - 1, MEM_BYTES - 8));
      end else begin
        it.immediate = 32'($urandom_range(63));
      end
    end
    last_dest = it.dest_reg;
    return it;
  endfunction

  task automatic push_insn(input logic [4:0] op, input logic [4:0] rd, input logic [4:0] rs1,
                           input logic [4:0] rs2, input logic [31:0] imm);
    item_t it;
    it.op = op;
    it.dest_reg = rd;
    it.src1_reg = rs1;
    it.src2_reg = rs2;
    it.immediate = imm;
    pending_items.push_back(it);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with no transaction pending, actual %h", $time, got);
      mismatch_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.reg_written !== want.reg_written) begin
        $display("%0t: reg_written expected %h actual %h", $time, want.reg_written,
                 got.reg_written);
        mismatch_count++;
      end
      if (got.written_reg !== want.written_reg) begin
        $display("%0t: written_reg expected %0d actual %0d", $time, want.written_reg,
                 got.written_reg);
        mismatch_count++;
      end
      if (got.written_value !== want.written_value) begin
        $display("%0t: written_value expected %h actual %h", $time, want.written_value,
                 got.written_value);
        mismatch_count++;
      end
      if (got.mem_written !== want.mem_written) begin
        $display("%0t: mem_written expected %h actual %h", $time, want.mem_written,
                 got.mem_written);
        mismatch_count++;
      end
      if (got.mem_address !== want.mem_address) begin
        $display("%0t: mem_address expected %h actual %h", $time, want.mem_address,
                 got.mem_address);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_results.push_back(execute_insn(item));
      end
      if (!item_valid || !item_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item_valid <= 1'b1;
          item <= pending_items.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        check_result(result);
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("rv32_subset_execute_unit_top_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < REG_COUNT; i++) begin
      arch_regs[i] = '0;
    end
    for (int i = 0; i < MEM_BYTES; i++) begin
      arch_mem[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      @(negedge clk);
      send_idle_pct = send_idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      if (phase == 0) begin
        push_insn(OP_LUI,  5'd1,  5'd0,  5'd0,  32'h0008_0000);
        push_insn(OP_LUI,  5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF);
        push_insn(OP_ADDI, 5'd2,  5'd0,  5'd0,  32'hFFFF_FFFF);
        push_insn(OP_ADDI, 5'd3,  5'd0,  5'd0,  32'h7FFF_FFFF);
        push_insn(OP_ADD,  5'd4,  5'd3,  5'd3,  32'h0);
        push_insn(OP_SUB,  5'd5,  5'd1,  5'd3,  32'h0);
        push_insn(OP_AND,  5'd6,  5'd2,  5'd31, 32'h0);
        push_insn(OP_OR,   5'd7,  5'd1,  5'd3,  32'h0);
        push_insn(OP_XOR,  5'd8,  5'd2,  5'd3,  32'h0);
        push_insn(OP_SLT,  5'd9,  5'd1,  5'd3,  32'h0);
        push_insn(OP_SLT,  5'd10, 5'd3,  5'd1,  32'h0);
        push_insn(OP_ADDI, 5'd11, 5'd0,  5'd0,  32'd33);
        push_insn(OP_SLL,  5'd12, 5'd2,  5'd11, 32'h0);
        push_insn(OP_SRA,  5'd13, 5'd1,  5'd11, 32'h0);
        push_insn(OP_SRA,  5'd14, 5'd2,  5'd31, 32'h0);
        push_insn(OP_ANDI, 5'd15, 5'd2,  5'd0,  32'h0F0F_0F0F);
        push_insn(OP_ORI,  5'd16, 5'd1,  5'd0,  32'h0000_0055);
        push_insn(OP_XORI, 5'd17, 5'd3,  5'd0,  32'hFFFF_FFFF);
        push_insn(OP_SLTI, 5'd18, 5'd1,  5'd0,  32'h0);
        push_insn(OP_SW,   5'd3,  5'd0,  5'd0,  32'(MEM_BYTES - 2));
        push_insn(OP_LW,   5'd19, 5'd0,  5'd0,  32'hFFFF_FFFE);
        push_insn(OP_LB,   5'd20, 5'd0,  5'd0,  32'(MEM_BYTES - 1));
        push_insn(OP_SB,   5'd2,  5'd0,  5'd0,  32'd3);
        push_insn(OP_LW,   5'd21, 5'd0,  5'd0,  32'd0);
        push_insn(OP_ADD,  5'd22, 5'd21, 5'd21, 32'h0);
        push_insn(OP_ADDI, 5'd0,  5'd3,  5'd0,  32'd5);
        push_insn(OP_LB,   5'd0,  5'd0,  5'd0,  32'd1);
        push_insn(5'd18,   5'd23, 5'd1,  5'd2,  32'hFFFF_FFFF);
        push_insn(5'd31,   5'd31, 5'd31, 5'd31, 32'h8000_0000);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pending_items.push_back(random_item());
      end
      while (pending_items.size() != 0 || item_valid || expected_results.size() != 0) begin
        @(negedge clk);
      end
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("rv32_subset_execute_unit_top_tb: clean");
    end else begin
      $display("rv32_subset_execute_unit_top_tb: errors");
    end
    $finish;
  end

endmodule
